### hw/rtl/vrcs_pkg.sv
package vrcs_pkg;

   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 2;
   localparam int REF_W = 2;
   localparam int CTX_W = 3;

   localparam logic [REF_W-1:0] REF_LAST = 2'd1;
   localparam logic [REF_W-1:0] REF_GOLDEN = 2'd2;
   localparam logic [REF_W-1:0] REF_ALTREF = 2'd3;

   typedef enum logic [REQ_USER_W-1:0] {
      CMD_INTER_FLAG = 3'd0,
      CMD_COMP_MODE = 3'd1,
      CMD_COMP_REF = 3'd2,
      CMD_SINGLE_FIRST = 3'd3,
      CMD_SINGLE_SECOND = 3'd4
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIXED_REF = 2'd0,
      CSR_VAR_REF_A = 2'd1,
      CSR_VAR_REF_B = 2'd2,
      CSR_VAR_SLOT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic avail;
      logic intra;
      logic single;
      logic [REF_W-1:0] r0;
      logic [REF_W-1:0] r1;
   } nbr_type;

   typedef struct packed {
      logic [REF_W-1:0] fixed_ref;
      logic [REF_W-1:0] var_ref_a;
      logic [REF_W-1:0] var_ref_b;
      logic var_slot;
   } cfg_type;

endpackage

### hw/rtl/vrcs_csr.sv
module vrcs_csr (
   input logic clock,
   input logic reset,
   input logic csr_valid,
   output logic csr_ready,
   input logic [vrcs_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [vrcs_pkg::CSR_DATA_W-1:0] csr_data,
   output vrcs_pkg::cfg_type cfg
);
   import vrcs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_FIXED_REF: cfg_in.fixed_ref = csr_data[REF_W-1:0];
            CSR_VAR_REF_A: cfg_in.var_ref_a = csr_data[REF_W-1:0];
            CSR_VAR_REF_B: cfg_in.var_ref_b = csr_data[REF_W-1:0];
            CSR_VAR_SLOT: cfg_in.var_slot = csr_data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fixed_ref <= REF_ALTREF;
         cfg_ff.var_ref_a <= REF_LAST;
         cfg_ff.var_ref_b <= REF_GOLDEN;
         cfg_ff.var_slot <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hw/rtl/vrcs_ctx.sv
module vrcs_ctx (
   input vrcs_pkg::cmd_type cmd,
   input vrcs_pkg::nbr_type above,
   input vrcs_pkg::nbr_type left,
   input vrcs_pkg::cfg_type cfg,
   output logic [vrcs_pkg::CTX_W-1:0] ctx
);
   import vrcs_pkg::*;

   function automatic logic [REF_W-1:0] var_of(nbr_type n, logic slot);
      if (n.single) return n.r0;
      return slot ? n.r1 : n.r0;
   endfunction

   function automatic logic uses(nbr_type n, logic [REF_W-1:0] f);
      return (n.r0 == f) || (n.r1 == f);
   endfunction

   function automatic logic [CTX_W-1:0] ctx_inter_flag(nbr_type a, nbr_type l);
      logic [CTX_W-1:0] c;
      if (a.avail && l.avail)
         c = (a.intra && l.intra) ? 3'd3 : ((a.intra || l.intra) ? 3'd1 : 3'd0);
      else if (a.avail) c = a.intra ? 3'd2 : 3'd0;
      else if (l.avail) c = l.intra ? 3'd2 : 3'd0;
      else c = 3'd0;
      return c;
   endfunction

   function automatic logic [CTX_W-1:0] ctx_comp_mode(nbr_type a, nbr_type l,
                                                     logic [REF_W-1:0] fx);
      logic [CTX_W-1:0] c;
      if (a.avail && l.avail) begin
         if (a.single && l.single) c = ((a.r0 == fx) != (l.r0 == fx)) ? 3'd1 : 3'd0;
         else if (a.single) c = ((a.r0 == fx) || a.intra) ? 3'd3 : 3'd2;
         else if (l.single) c = ((l.r0 == fx) || l.intra) ? 3'd3 : 3'd2;
         else c = 3'd4;
      end else if (a.avail) begin
         c = a.single ? ((a.r0 == fx) ? 3'd1 : 3'd0) : 3'd3;
      end else if (l.avail) begin
         c = l.single ? ((l.r0 == fx) ? 3'd1 : 3'd0) : 3'd3;
      end else begin
         c = 3'd1;
      end
      return c;
   endfunction

   function automatic logic [CTX_W-1:0] comp_ref_one(nbr_type n, cfg_type k);
      logic [CTX_W-1:0] c;
      if (n.intra) c = 3'd2;
      else if (n.single) c = (n.r0 != k.var_ref_b) ? 3'd3 : 3'd0;
      else c = (var_of(n, k.var_slot) != k.var_ref_b) ? 3'd4 : 3'd0;
      return c;
   endfunction

   function automatic logic [CTX_W-1:0] ctx_comp_ref(nbr_type a, nbr_type l, cfg_type k);
      logic [REF_W-1:0] va;
      logic [REF_W-1:0] vl;
      logic [REF_W-1:0] vb;
      logic [REF_W-1:0] vrfc;
      logic [REF_W-1:0] rfs;
      logic [CTX_W-1:0] c;
      va = var_of(a, k.var_slot);
      vl = var_of(l, k.var_slot);
      vb = k.var_ref_b;
      vrfc = l.single ? va : vl;
      rfs = a.single ? va : vl;
      if (a.avail && l.avail) begin
         if (a.intra && l.intra) c = 3'd2;
         else if (l.intra) c = (va != vb) ? 3'd3 : 3'd1;
         else if (a.intra) c = (vl != vb) ? 3'd3 : 3'd1;
         else if (va == vl && vb == va) c = 3'd0;
         else if (a.single && l.single) begin
            if ((va == k.fixed_ref && vl == k.var_ref_a) ||
                (vl == k.fixed_ref && va == k.var_ref_a)) c = 3'd4;
            else c = (va == vl) ? 3'd3 : 3'd1;
         end else if (a.single || l.single) begin
            if (vrfc == vb && rfs != vb) c = 3'd1;
            else if (rfs == vb && vrfc != vb) c = 3'd2;
            else c = 3'd4;
         end else begin
            c = (va == vl) ? 3'd4 : 3'd2;
         end
      end else if (a.avail) begin
         c = comp_ref_one(a, k);
      end else if (l.avail) begin
         c = comp_ref_one(l, k);
      end else begin
         c = 3'd2;
      end
      return c;
   endfunction

   function automatic logic [CTX_W-1:0] single1_one(nbr_type n);
      logic [CTX_W-1:0] c;
      if (n.single) c = (n.r0 == REF_LAST) ? 3'd4 : 3'd0;
      else c = uses(n, REF_LAST) ? 3'd2 : 3'd1;
      return c;
   endfunction

   function automatic logic [CTX_W-1:0] ctx_single1(nbr_type a, nbr_type l);
      nbr_type s;
      nbr_type m;
      logic [CTX_W-1:0] c;
      logic al;
      logic ll;
      s = a.single ? a : l;
      m = a.single ? l : a;
      al = (a.r0 == REF_LAST);
      ll = (l.r0 == REF_LAST);
      if (a.avail && l.avail) begin
         if (a.intra && l.intra) c = 3'd2;
         else if (l.intra) c = single1_one(a);
         else if (a.intra) c = single1_one(l);
         else if (a.single && l.single) c = (al && ll) ? 3'd4 : ((al || ll) ? 3'd2 : 3'd0);
         else if (!a.single && !l.single)
            c = (uses(a, REF_LAST) || uses(l, REF_LAST)) ? 3'd2 : 3'd1;
         else
            c = {2'b00, uses(m, REF_LAST)} + ((s.r0 == REF_LAST) ? 3'd3 : 3'd0);
      end else if (a.avail) begin
         c = a.intra ? 3'd2 : single1_one(a);
      end else if (l.avail) begin
         c = l.intra ? 3'd2 : single1_one(l);
      end else begin
         c = 3'd2;
      end
      return c;
   endfunction

   function automatic logic [CTX_W-1:0] single2_one(nbr_type n);
      logic [CTX_W-1:0] c;
      if (n.intra || (n.single && n.r0 == REF_LAST)) c = 3'd2;
      else if (n.single) c = (n.r0 == REF_GOLDEN) ? 3'd4 : 3'd0;
      else c = uses(n, REF_GOLDEN) ? 3'd3 : 3'd0;
      return c;
   endfunction

   function automatic logic [CTX_W-1:0] single2_by_intra(nbr_type n);
      logic [CTX_W-1:0] c;
      if (n.single) begin
         if (n.r0 == REF_LAST) c = 3'd3;
         else c = (n.r0 == REF_GOLDEN) ? 3'd4 : 3'd0;
      end else begin
         c = uses(n, REF_GOLDEN) ? 3'd3 : 3'd1;
      end
      return c;
   endfunction

   function automatic logic [CTX_W-1:0] ctx_single2(nbr_type a, nbr_type l);
      nbr_type s;
      nbr_type m;
      logic [CTX_W-1:0] c;
      logic al;
      logic ll;
      logic ag;
      logic lg;
      logic g;
      s = a.single ? a : l;
      m = a.single ? l : a;
      al = (a.r0 == REF_LAST);
      ll = (l.r0 == REF_LAST);
      ag = (a.r0 == REF_GOLDEN);
      lg = (l.r0 == REF_GOLDEN);
      g = uses(m, REF_GOLDEN);
      if (a.avail && l.avail) begin
         if (a.intra && l.intra) c = 3'd2;
         else if (l.intra) c = single2_by_intra(a);
         else if (a.intra) c = single2_by_intra(l);
         else if (a.single && l.single) begin
            if (al && ll) c = 3'd3;
            else if (al) c = lg ? 3'd4 : 3'd0;
            else if (ll) c = ag ? 3'd4 : 3'd0;
            else c = (ag && lg) ? 3'd4 : ((ag || lg) ? 3'd2 : 3'd0);
         end else if (!a.single && !l.single) begin
            if (a.r0 == l.r0 && a.r1 == l.r1) c = uses(a, REF_GOLDEN) ? 3'd3 : 3'd0;
            else c = 3'd2;
         end else begin
            if (s.r0 == REF_GOLDEN) c = g ? 3'd4 : 3'd3;
            else if (s.r0 != REF_ALTREF) c = g ? 3'd3 : 3'd1;
            else c = {2'b00, g};
         end
      end else if (a.avail) begin
         c = single2_one(a);
      end else if (l.avail) begin
         c = single2_one(l);
      end else begin
         c = 3'd2;
      end
      return c;
   endfunction

   always_comb begin
      unique case (cmd)
         CMD_INTER_FLAG: ctx = ctx_inter_flag(above, left);
         CMD_COMP_MODE: ctx = ctx_comp_mode(above, left, cfg.fixed_ref);
         CMD_COMP_REF: ctx = ctx_comp_ref(above, left, cfg);
         CMD_SINGLE_FIRST: ctx = ctx_single1(above, left);
         CMD_SINGLE_SECOND: ctx = ctx_single2(above, left);
         default: ctx = '0;
      endcase
   end

endmodule

### hw/rtl/vp9_reference_context_select.sv
// Derives the VP9 probability context (0..4) for the intra/inter flag, comp_mode, comp_ref and
// the two single_ref elements from the above and left neighbours, one beat per clock sustained
// while the receiver keeps rsp_tready high. A beat lands in an input register, and the context
// logic sits between that and the result register; a stalled result backs up into the input
// register before req_tready drops. The CSR port is always ready and must be written only while
// no beat is in flight. Commands 5 to 7 return context 0.
module vp9_reference_context_select (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   // above_available, left_available, above_intra, left_intra, above_single, left_single,
   // above_ref_first[1:0], above_ref_second[1:0], left_ref_first[1:0], left_ref_second[1:0]
   input logic [vrcs_pkg::REQ_DATA_W-1:0] req_tdata,
   // command[2:0]
   input logic [vrcs_pkg::REQ_USER_W-1:0] req_tuser,
   output logic rsp_tvalid,
   input logic rsp_tready,
   // context_index[2:0]
   output logic [vrcs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic csr_valid,
   output logic csr_ready,
   input logic [vrcs_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [vrcs_pkg::CSR_DATA_W-1:0] csr_data
);
   import vrcs_pkg::*;

   cfg_type cfg;

   logic s1_valid_ff;
   logic s1_valid_in;
   cmd_type s1_cmd_ff;
   nbr_type s1_above_ff;
   nbr_type s1_left_ff;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic [CTX_W-1:0] rsp_ctx_ff;
   logic [CTX_W-1:0] ctx;
   logic out_free;
   logic req_beat;
   logic advance;
   nbr_type req_above;
   nbr_type req_left;

   vrcs_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .cfg(cfg)
   );

   vrcs_ctx u_ctx (
      .cmd(s1_cmd_ff),
      .above(s1_above_ff),
      .left(s1_left_ff),
      .cfg(cfg),
      .ctx(ctx)
   );

   assign req_above = '{avail: req_tdata[0], intra: req_tdata[2], single: req_tdata[4],
                        r0: req_tdata[7:6], r1: req_tdata[9:8]};
   assign req_left = '{avail: req_tdata[1], intra: req_tdata[3], single: req_tdata[5],
                       r0: req_tdata[11:10], r1: req_tdata[13:12]};

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign advance = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_beat = req_tvalid && req_tready;

   assign s1_valid_in = req_beat || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_cmd_ff <= cmd_type'(req_tuser);
         s1_above_ff <= req_above;
         s1_left_ff <= req_left;
      end
      if (advance) begin
         rsp_ctx_ff <= ctx;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(RSP_DATA_W-CTX_W){1'b0}}, rsp_ctx_ff};

endmodule

### hw/rtl/vrcs_checker.sv
module vrcs_checker (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [7:0] rsp_tdata
);

   ap_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   ap_ctx_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= 3'd4 && rsp_tdata[7:3] == 5'd0)
      else $error("context out of range");

   ap_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req stalled without a blocked rsp beat");

   ap_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   ap_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !rsp_tvalid |=> !rsp_tvalid)
      else $error("rsp beat without a request");

endmodule

bind vp9_reference_context_select vrcs_checker u_vrcs_checker (
   .clock(clock),
   .reset(reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import vrcs_pkg::*;

   localparam logic [REQ_USER_W-1:0] CMD_UNUSED_A = 3'd5;
   localparam logic [REQ_USER_W-1:0] CMD_UNUSED_B = 3'd6;
   localparam logic [REQ_USER_W-1:0] CMD_UNUSED_C = 3'd7;
   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 190;
   localparam int HOLD_CYCLES = 120;

   typedef struct {
      logic [REQ_USER_W-1:0] cmd;
      nbr_type above;
      nbr_type left;
      bit known;
      logic [CTX_W-1:0] ctx;
   } probe_type;

   typedef struct {
      bit known;
      logic [CTX_W-1:0] ctx;
   } ctx_tag_type;

   typedef struct {
      logic [REQ_USER_W-1:0] cmd;
      logic [CTX_W-1:0] ctx;
   } ctx_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   cfg_type frame_refs;
   ctx_tag_type row_tags[$];
   ctx_entry_type pending_contexts[$];
   int accepted_count = 0;
   int returned_count = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int settings_seen = 0;

   vp9_reference_context_select dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d contexts outstanding", $time,
                  cycle_count, accepted_count - returned_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic int unsigned var_ref_of(nbr_type n);
      if (n.single) return n.r0;
      return frame_refs.var_slot ? n.r1 : n.r0;
   endfunction

   function automatic int unsigned uses_ref(nbr_type n, logic [REF_W-1:0] f);
      return (n.r0 == f || n.r1 == f) ? 1 : 0;
   endfunction

   function automatic int unsigned inter_flag_ctx(nbr_type a, nbr_type l);
      if (a.avail && l.avail) return (a.intra && l.intra) ? 3 : ((a.intra || l.intra) ? 1 : 0);
      if (a.avail) return a.intra ? 2 : 0;
      if (l.avail) return l.intra ? 2 : 0;
      return 0;
   endfunction

   function automatic int unsigned comp_mode_ctx(nbr_type a, nbr_type l);
      logic [REF_W-1:0] fx;
      fx = frame_refs.fixed_ref;
      if (a.avail && l.avail) begin
         if (a.single && l.single) return ((a.r0 == fx) != (l.r0 == fx)) ? 1 : 0;
         if (a.single) return 2 + ((a.r0 == fx || a.intra) ? 1 : 0);
         if (l.single) return 2 + ((l.r0 == fx || l.intra) ? 1 : 0);
         return 4;
      end
      if (a.avail) return a.single ? ((a.r0 == fx) ? 1 : 0) : 3;
      if (l.avail) return l.single ? ((l.r0 == fx) ? 1 : 0) : 3;
      return 1;
   endfunction

   function automatic int unsigned comp_ref_lone(nbr_type n);
      if (n.intra) return 2;
      if (n.single) return (n.r0 != frame_refs.var_ref_b) ? 3 : 0;
      return (var_ref_of(n) != frame_refs.var_ref_b) ? 4 : 0;
   endfunction

   function automatic int unsigned comp_ref_ctx(nbr_type a, nbr_type l);
      int unsigned vb, va, vl, vrfc, rfs;
      vb = frame_refs.var_ref_b;
      if (a.avail && l.avail) begin
         if (a.intra && l.intra) return 2;
         if (l.intra) return 1 + 2 * ((var_ref_of(a) != vb) ? 1 : 0);
         if (a.intra) return 1 + 2 * ((var_ref_of(l) != vb) ? 1 : 0);
         va = var_ref_of(a);
         vl = var_ref_of(l);
         if (va == vl && vb == va) return 0;
         if (a.single && l.single) begin
            if ((va == frame_refs.fixed_ref && vl == frame_refs.var_ref_a) ||
                (vl == frame_refs.fixed_ref && va == frame_refs.var_ref_a)) return 4;
            return (va == vl) ? 3 : 1;
         end
         if (a.single || l.single) begin
            vrfc = l.single ? va : vl;
            rfs = a.single ? va : vl;
            if (vrfc == vb && rfs != vb) return 1;
            if (rfs == vb && vrfc != vb) return 2;
            return 4;
         end
         return (va == vl) ? 4 : 2;
      end
      if (a.avail) return comp_ref_lone(a);
      if (l.avail) return comp_ref_lone(l);
      return 2;
   endfunction

   function automatic int unsigned single_first_lone(nbr_type n);
      if (n.single) return (n.r0 == REF_LAST) ? 4 : 0;
      return 1 + uses_ref(n, REF_LAST);
   endfunction

   function automatic int unsigned single_first_ctx(nbr_type a, nbr_type l);
      nbr_type s, c;
      int unsigned ctx;
      if (a.avail && l.avail) begin
         if (a.intra && l.intra) return 2;
         if (l.intra) return single_first_lone(a);
         if (a.intra) return single_first_lone(l);
         if (a.single && l.single)
            return 2 * ((a.r0 == REF_LAST) ? 1 : 0) + 2 * ((l.r0 == REF_LAST) ? 1 : 0);
         if (!a.single && !l.single)
            return 1 + ((uses_ref(a, REF_LAST) != 0 || uses_ref(l, REF_LAST) != 0) ? 1 : 0);
         s = a.single ? a : l;
         c = a.single ? l : a;
         ctx = uses_ref(c, REF_LAST);
         if (s.r0 == REF_LAST) ctx += 3;
         return ctx;
      end
      if (a.avail) return a.intra ? 2 : single_first_lone(a);
      if (l.avail) return l.intra ? 2 : single_first_lone(l);
      return 2;
   endfunction

   function automatic int unsigned single_second_lone(nbr_type n);
      if (n.intra || (n.single && n.r0 == REF_LAST)) return 2;
      if (n.single) return (n.r0 == REF_GOLDEN) ? 4 : 0;
      return 3 * uses_ref(n, REF_GOLDEN);
   endfunction

   function automatic int unsigned single_second_by_intra(nbr_type n);
      if (n.single) begin
         if (n.r0 == REF_LAST) return 3;
         return (n.r0 == REF_GOLDEN) ? 4 : 0;
      end
      return 1 + 2 * uses_ref(n, REF_GOLDEN);
   endfunction

   function automatic int unsigned single_second_ctx(nbr_type a, nbr_type l);
      nbr_type s, c;
      bit al, ll;
      int unsigned g;
      if (a.avail && l.avail) begin
         if (a.intra && l.intra) return 2;
         if (l.intra) return single_second_by_intra(a);
         if (a.intra) return single_second_by_intra(l);
         if (a.single && l.single) begin
            al = (a.r0 == REF_LAST);
            ll = (l.r0 == REF_LAST);
            if (al && ll) return 3;
            if (al) return (l.r0 == REF_GOLDEN) ? 4 : 0;
            if (ll) return (a.r0 == REF_GOLDEN) ? 4 : 0;
            return 2 * ((a.r0 == REF_GOLDEN) ? 1 : 0) + 2 * ((l.r0 == REF_GOLDEN) ? 1 : 0);
         end
         if (!a.single && !l.single) begin
            if (a.r0 == l.r0 && a.r1 == l.r1) return 3 * uses_ref(a, REF_GOLDEN);
            return 2;
         end
         s = a.single ? a : l;
         c = a.single ? l : a;
         g = uses_ref(c, REF_GOLDEN);
         if (s.r0 == REF_GOLDEN) return g + 3;
         if (s.r0 != REF_ALTREF) return 1 + 2 * g;
         return g;
      end
      if (a.avail) return single_second_lone(a);
      if (l.avail) return single_second_lone(l);
      return 2;
   endfunction

   function automatic logic [CTX_W-1:0] derive_context(logic [REQ_USER_W-1:0] cmd,
                                                       nbr_type a, nbr_type l);
      int unsigned ctx;
      case (cmd)
         CMD_INTER_FLAG: ctx = inter_flag_ctx(a, l);
         CMD_COMP_MODE: ctx = comp_mode_ctx(a, l);
         CMD_COMP_REF: ctx = comp_ref_ctx(a, l);
         CMD_SINGLE_FIRST: ctx = single_first_ctx(a, l);
         CMD_SINGLE_SECOND: ctx = single_second_ctx(a, l);
         default: ctx = 0;
      endcase
      return CTX_W'(ctx);
   endfunction

   function automatic nbr_type nb(logic avail, logic intra, logic single,
                                  logic [REF_W-1:0] r0, logic [REF_W-1:0] r1);
      nbr_type n;
      n.avail = avail;
      n.intra = intra;
      n.single = single;
      n.r0 = r0;
      n.r1 = r1;
      return n;
   endfunction

   function automatic probe_type probe(logic [REQ_USER_W-1:0] cmd, nbr_type a, nbr_type l,
                                       bit known, int unsigned ctx);
      probe_type p;
      p.cmd = cmd;
      p.above = a;
      p.left = l;
      p.known = known;
      p.ctx = CTX_W'(ctx);
      return p;
   endfunction

   function automatic nbr_type random_nbr();
      return nb($urandom_range(0, 7) != 0, $urandom_range(0, 3) == 0,
                1'($urandom_range(0, 1)), REF_W'($urandom_range(0, 3)),
                REF_W'($urandom_range(0, 3)));
   endfunction

   function automatic logic [REQ_USER_W-1:0] random_cmd();
      if ($urandom_range(0, 15) == 0) return REQ_USER_W'($urandom_range(5, 7));
      return REQ_USER_W'($urandom_range(0, 4));
   endfunction

   // accept beat, predict or take the typed context
   always @(posedge clock) begin
      nbr_type a, l;
      ctx_tag_type tag;
      ctx_entry_type e;
      if (!reset && req_tvalid && req_tready) begin
         a = nb(req_tdata[0], req_tdata[2], req_tdata[4], req_tdata[7:6], req_tdata[9:8]);
         l = nb(req_tdata[1], req_tdata[3], req_tdata[5], req_tdata[11:10], req_tdata[13:12]);
         tag = row_tags.pop_front();
         e.cmd = req_tuser;
         e.ctx = tag.known ? tag.ctx : derive_context(req_tuser, a, l);
         pending_contexts.push_back(e);
         accepted_count = accepted_count + 1;
      end
   end

   always @(posedge clock) begin
      ctx_entry_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_contexts.size() == 0) begin
            $display("%0t: unexpected context beat, expected none, actual %0d", $time,
                     rsp_tdata[CTX_W-1:0]);
            mismatch_count <= mismatch_count + 1;
         end else begin
            e = pending_contexts.pop_front();
            returned_count = returned_count + 1;
            if (rsp_tdata[CTX_W-1:0] !== e.ctx) begin
               $display("%0t: context mismatch cmd %0d expected %0d actual %0d", $time,
                        e.cmd, e.ctx, rsp_tdata[CTX_W-1:0]);
               mismatch_count <= mismatch_count + 1;
            end
         end
      end
   end

   // receiver: free-running segments, every sixth one a long hold-off
   initial begin
      int seg;
      int mode;
      int len;
      seg = 0;
      @(posedge clock);
      forever begin
         seg++;
         if (seg % 6 == 4) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 2);
            len = $urandom_range(10, 60);
            repeat (len) begin
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= $urandom_range(0, 3) != 0;
                  default: rsp_tready <= $urandom_range(0, 3) == 0;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   task automatic send_beat(logic [REQ_USER_W-1:0] cmd, nbr_type a, nbr_type l, bit known,
                            logic [CTX_W-1:0] ctx);
      ctx_tag_type tag;
      tag.known = known;
      tag.ctx = ctx;
      row_tags.push_back(tag);
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {2'b00, l.r1, l.r0, a.r1, a.r0, l.single, a.single, l.intra, a.intra,
                    l.avail, a.avail};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         int gap;
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
   endtask

   task automatic drain();
      wait (returned_count == accepted_count && row_tags.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_FIXED_REF: frame_refs.fixed_ref = value;
         CSR_VAR_REF_A: frame_refs.var_ref_a = value;
         CSR_VAR_REF_B: frame_refs.var_ref_b = value;
         default: frame_refs.var_slot = value[0];
      endcase
   endtask

   task automatic load_frame_refs(cfg_type c);
      write_reg(CSR_FIXED_REF, c.fixed_ref);
      write_reg(CSR_VAR_REF_A, c.var_ref_a);
      write_reg(CSR_VAR_REF_B, c.var_ref_b);
      write_reg(CSR_VAR_SLOT, {1'b0, c.var_slot});
      csr_valid <= 1'b0;
      settings_seen++;
   endtask

   initial begin
      probe_type probes[$];
      cfg_type c;
      nbr_type off, ones;
      int p;
      int k;

      frame_refs.fixed_ref = REF_ALTREF;
      frame_refs.var_ref_a = REF_LAST;
      frame_refs.var_ref_b = REF_GOLDEN;
      frame_refs.var_slot = 1'b0;
      settings_seen = 1;
      off = nb(0, 0, 0, 0, 0);
      ones = nb(1, 1, 1, 3, 3);

      probes.push_back(probe(CMD_INTER_FLAG, off, off, 1, 0));
      probes.push_back(probe(CMD_COMP_MODE, off, off, 1, 1));
      probes.push_back(probe(CMD_COMP_REF, off, off, 1, 2));
      probes.push_back(probe(CMD_SINGLE_FIRST, off, off, 1, 2));
      probes.push_back(probe(CMD_SINGLE_SECOND, off, off, 1, 2));
      probes.push_back(probe(CMD_UNUSED_A, ones, ones, 1, 0));
      probes.push_back(probe(CMD_UNUSED_C, ones, ones, 1, 0));
      probes.push_back(probe(CMD_UNUSED_B, off, off, 1, 0));
      probes.push_back(probe(CMD_INTER_FLAG, ones, nb(1, 1, 0, 0, 0), 1, 3));
      probes.push_back(probe(CMD_INTER_FLAG, nb(1, 1, 0, 2, 1), nb(0, 1, 1, 3, 3), 1, 2));
      probes.push_back(probe(CMD_INTER_FLAG, nb(0, 1, 1, 3, 3), nb(1, 0, 1, 1, 0), 1, 0));
      probes.push_back(probe(CMD_COMP_MODE, nb(1, 0, 0, 1, 2), nb(1, 0, 0, 3, 2), 1, 4));
      probes.push_back(probe(CMD_COMP_MODE, nb(1, 0, 0, 1, 3), ones ^ nb(1, 0, 0, 0, 0), 1, 3));
      probes.push_back(probe(CMD_COMP_REF, nb(1, 1, 1, 0, 0), nb(1, 1, 1, 0, 0), 1, 2));
      probes.push_back(probe(CMD_SINGLE_FIRST, nb(1, 1, 1, 0, 0), nb(1, 1, 0, 2, 3), 1, 2));
      probes.push_back(probe(CMD_SINGLE_SECOND, nb(1, 1, 0, 1, 2), nb(1, 1, 1, 0, 0), 1, 2));
      probes.push_back(probe(CMD_SINGLE_FIRST, nb(1, 0, 1, 1, 0), nb(1, 0, 1, 1, 0), 1, 4));
      probes.push_back(probe(CMD_SINGLE_SECOND, nb(1, 0, 1, 1, 0), nb(1, 0, 1, 1, 0), 1, 3));
      probes.push_back(probe(CMD_COMP_MODE, nb(1, 0, 1, 3, 0), nb(1, 0, 1, 1, 0), 0, 0));
      probes.push_back(probe(CMD_COMP_REF, nb(1, 0, 1, 3, 0), nb(1, 0, 1, 1, 0), 0, 0));
      probes.push_back(probe(CMD_COMP_REF, nb(1, 1, 0, 2, 3), nb(1, 0, 0, 1, 2), 0, 0));
      probes.push_back(probe(CMD_SINGLE_SECOND, nb(1, 0, 1, 2, 0), nb(1, 0, 0, 1, 2), 0, 0));
      probes.push_back(probe(CMD_SINGLE_FIRST, ones, ones, 0, 0));
      probes.push_back(probe(CMD_COMP_REF, nb(1, 0, 0, 1, 2), nb(1, 0, 0, 3, 2), 0, 0));
      probes.push_back(probe(CMD_SINGLE_SECOND, ones, ones, 0, 0));

      wait (!reset);
      @(posedge clock);
      burst_left = $urandom_range(1, 24);
      foreach (probes[i])
         send_beat(probes[i].cmd, probes[i].above, probes[i].left, probes[i].known,
                   probes[i].ctx);
      req_tvalid <= 1'b0;

      for (p = 0; p < PHASES; p++) begin
         drain();
         case (p)
            0: c = '{fixed_ref: 2'd0, var_ref_a: 2'd0, var_ref_b: 2'd0, var_slot: 1'b0};
            1: c = '{fixed_ref: 2'd3, var_ref_a: 2'd3, var_ref_b: 2'd3, var_slot: 1'b1};
            2: c = '{fixed_ref: 2'd2, var_ref_a: 2'd1, var_ref_b: 2'd1, var_slot: 1'b0};
            3: c = '{fixed_ref: 2'd1, var_ref_a: 2'd2, var_ref_b: 2'd3, var_slot: 1'b1};
            default: c = cfg_type'(7'($urandom_range(0, 127)));
         endcase
         load_frame_refs(c);
         for (k = 0; k < ITEMS_PER_PHASE; k++)
            send_beat(random_cmd(), random_nbr(), random_nbr(), 0, '0);
         req_tvalid <= 1'b0;
      end

      drain();
      $display("Checked %0d context beats across %0d reference register settings,", accepted_count,
               settings_seen);
      $display("all five elements, unused commands and unavailable or contradictory neighbours.");
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
